### hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication with a delayed consequent
`define SPD_ASSERT_TWO(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### hdl/spd_pkg.sv
// shared types, register codes and reset values for the strike peak-drop detector
// no dependencies
package spd_pkg;

    localparam int FRACTION_BITS_DEF = 8;
    localparam int SAMPLE_W          = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int HOLDOFF_W         = 6;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DROP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_EPS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 3'd4;

    localparam logic [15:0]          ALPHA_RST    = 16'd15729;
    localparam logic [15:0]          MIN_PEAK_RST = 16'd2800;
    localparam logic [15:0]          MIN_DROP_RST = 16'd1100;
    localparam logic [15:0]          SLOPE_EPS_RST = 16'd307;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST  = 6'd16;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic                strike;
        logic [SAMPLE_W-1:0] smoothed;
        logic                in_descent;
    } result_t;

    typedef struct packed {
        logic [15:0]          smoothing_alpha;
        logic [15:0]          min_peak;
        logic [15:0]          min_drop;
        logic [15:0]          slope_epsilon;
        logic [HOLDOFF_W-1:0] holdoff_length;
    } spd_cfg_t;

    // stage one status toward the decision stage
    typedef struct packed {
        logic valid;
        logic mode;
    } spd_ctl_t;

endpackage

### hdl/spd_avg.sv
// stage one: exponential average update and its register
// depends on spd_pkg
module spd_avg
    import spd_pkg::*;
#(
    parameter int FracBits = FRACTION_BITS_DEF,
    localparam int AvgW = SAMPLE_W + FracBits
)(
    input  logic            clk,
    input  logic            rst_n,
    input  item_t           item,
    input  logic            take,
    input  logic [15:0]     alpha,
    input  logic            advance,
    output spd_ctl_t        ctl,
    output logic [AvgW-1:0] avg,
    output logic [AvgW-1:0] prev
);

    logic [AvgW-1:0]          avg_reg;
    logic [AvgW-1:0]          avg_next;
    logic [AvgW-1:0]          prev_reg;
    logic                     mode_reg;
    logic                     valid_reg;
    logic                     valid_next;
    logic [AvgW-1:0]          x;
    logic signed [AvgW:0]     diff;
    logic signed [AvgW+17:0]  prod;
    logic signed [AvgW+17:0]  sum;

    // avg + alpha*(x - avg) equals the weighted sum of both terms
    assign x    = {item.sample, {FracBits{1'b0}}};
    assign diff = $signed({1'b0, x}) - $signed({1'b0, avg_reg});
    assign prod = $signed({1'b0, alpha}) * diff;
    assign sum  = $signed({2'b00, avg_reg, 16'h0000}) + prod
                + $signed({{(AvgW + 2){1'b0}}, 16'h8000});

    assign avg_next   = item.mode ? x : sum[AvgW+15:16];
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                avg_reg <= avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev_reg <= avg_reg;
            mode_reg <= item.mode;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.mode  = mode_reg;
    assign avg       = avg_reg;
    assign prev      = prev_reg;

endmodule

### hdl/spd_decide.sv
// stage two: peak tracking, descent and holdoff control, result register
// depends on spd_pkg
module spd_decide
    import spd_pkg::*;
#(
    parameter int FracBits = FRACTION_BITS_DEF,
    localparam int AvgW = SAMPLE_W + FracBits
)(
    input  logic            clk,
    input  logic            rst_n,
    input  spd_ctl_t        ctl,
    input  logic [AvgW-1:0] avg,
    input  logic [AvgW-1:0] prev,
    input  spd_cfg_t        cfg,
    output logic            advance,
    output logic            result_valid,
    input  logic            result_ready,
    output result_t         result
);

    logic [AvgW-1:0]      peak_reg;
    logic [AvgW-1:0]      peak_next;
    logic [AvgW-1:0]      peak_max;
    logic                 descent_reg;
    logic                 descent_next;
    logic [HOLDOFF_W-1:0] holdoff_reg;
    logic [HOLDOFF_W-1:0] holdoff_next;
    logic                 fired_reg;
    logic                 fired_next;
    logic                 strike;
    logic                 valid_reg;
    result_t              result_reg;
    logic                 load;
    logic [AvgW-1:0]      eps;
    logic [AvgW-1:0]      min_peak_s;
    logic [AvgW-1:0]      min_drop_s;
    logic                 falling;
    logic                 rising;
    logic                 drop_hit;

    // epsilon is q8.8, moved onto the average's fraction scale
    assign eps        = ({{FracBits{1'b0}}, cfg.slope_epsilon} << FracBits) >> 8;
    assign min_peak_s = {cfg.min_peak, {FracBits{1'b0}}};
    assign min_drop_s = {cfg.min_drop, {FracBits{1'b0}}};

    assign falling  = {1'b0, prev} > ({1'b0, avg} + {1'b0, eps});
    assign rising   = {1'b0, avg} > ({1'b0, prev} + {1'b0, eps});
    assign drop_hit = {1'b0, peak_reg} >= ({1'b0, avg} + {1'b0, min_drop_s});
    assign peak_max = (avg > peak_reg) ? avg : peak_reg;

    assign advance = !valid_reg || result_ready;
    assign load    = ctl.valid && advance;

    always_comb
    begin
        peak_next    = peak_reg;
        descent_next = descent_reg;
        holdoff_next = holdoff_reg;
        fired_next   = fired_reg;
        strike       = 1'b0;
        if (ctl.mode)
        begin
            peak_next    = avg;
            descent_next = 1'b0;
            holdoff_next = '0;
            fired_next   = 1'b0;
        end
        else if (holdoff_reg != '0)
        begin
            holdoff_next = holdoff_reg - 1'b1;
        end
        else if (!descent_reg)
        begin
            peak_next = peak_max;
            if (peak_max >= min_peak_s && falling)
            begin
                fired_next   = 1'b0;
                descent_next = 1'b1;
            end
        end
        else if (!fired_reg && drop_hit)
        begin
            fired_next   = 1'b1;
            holdoff_next = cfg.holdoff_length;
            strike       = 1'b1;
        end
        else if (rising)
        begin
            // re-arm the search from the current level
            peak_next    = avg;
            descent_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg    <= '0;
            descent_reg <= 1'b0;
            holdoff_reg <= '0;
            fired_reg   <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= ctl.valid;
            end
            if (load)
            begin
                peak_reg    <= peak_next;
                descent_reg <= descent_next;
                holdoff_reg <= holdoff_next;
                fired_reg   <= fired_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.strike     <= strike;
            result_reg.smoothed   <= avg[AvgW-1:FracBits];
            result_reg.in_descent <= descent_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

### hdl/strike_peak_drop_detector.sv
// an accepted item passes the stage one and result registers, one result per item
// throughput: one item per cycle while the result side does not stall; the average
// update is one multiply-add closing on itself; peak and holdoff state are in stage two
// reset: config registers return to their defaults; average, peak, descent, holdoff and
// fired state clear to zero; no clearing pass, items are taken right after reset
module strike_peak_drop_detector
    import spd_pkg::*;
#(
    parameter int FracBits = FRACTION_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AvgW = SAMPLE_W + FracBits;

    spd_cfg_t        cfg_reg;
    spd_ctl_t        ctl;
    logic [AvgW-1:0] avg;
    logic [AvgW-1:0] prev;
    logic            advance;
    logic            take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_alpha <= ALPHA_RST;
            cfg_reg.min_peak        <= MIN_PEAK_RST;
            cfg_reg.min_drop        <= MIN_DROP_RST;
            cfg_reg.slope_epsilon   <= SLOPE_EPS_RST;
            cfg_reg.holdoff_length  <= HOLDOFF_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_ALPHA:     cfg_reg.smoothing_alpha <= cfg_data;
                REG_MIN_PEAK:  cfg_reg.min_peak        <= cfg_data;
                REG_MIN_DROP:  cfg_reg.min_drop        <= cfg_data;
                REG_SLOPE_EPS: cfg_reg.slope_epsilon   <= cfg_data;
                REG_HOLDOFF:   cfg_reg.holdoff_length  <= cfg_data[HOLDOFF_W-1:0];
                default:       ;
            endcase
        end
    end

    assign item_ready = !ctl.valid || advance;
    assign take       = item_valid && item_ready;

    spd_avg #(
        .FracBits (FracBits)
    ) u_avg (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .take    (take),
        .alpha   (cfg_reg.smoothing_alpha),
        .advance (advance),
        .ctl     (ctl),
        .avg     (avg),
        .prev    (prev)
    );

    spd_decide #(
        .FracBits (FracBits)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .avg          (avg),
        .prev         (prev),
        .cfg          (cfg_reg),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### hdl/spd_checker.sv
// port-level checks for the strike peak-drop detector, bound to the top level
// depends on spd_pkg and assert_macros.svh
`include "assert_macros.svh"

module spd_checker
    import spd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    `SPD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result), "result beat changed while stalled")
    `SPD_ASSERT_NOW(a_strike_in_descent, result_valid && result.strike,
        result.in_descent, "strike reported outside descent")
    `SPD_ASSERT_NOW(a_ready_when_empty, !result_valid, item_ready,
        "input stalled with empty output")
    `SPD_ASSERT_TWO(a_result_follows, item_valid && item_ready && !result_valid,
        result_valid, "accepted item produced no result")

endmodule

bind strike_peak_drop_detector spd_checker u_spd_checker (.*);

### tb/strike_peak_drop_detector_test.sv
// self-checking testbench for strike_peak_drop_detector: two directed openers, then random
// strike shapes, samples and loads under several register settings; depends on spd_pkg and the rtl
module strike_peak_drop_detector_test
    import spd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_STEP   = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;
    localparam int   NUM_PHASES  = 11;
    localparam int   PHASE_ITEMS = 84;
    localparam int   HOLD_PHASE  = 5;
    localparam int   DRAIN_PHASE = 7;
    localparam int   LONG_HOLD   = 80;

    typedef logic [SAMPLE_W+FRACTION_BITS_DEF-1:0] level_t;

    // expected results of the detector, kept in step with the accepted samples
    class strike_tracker;
        spd_cfg_t             regs;
        level_t               avg, prev_avg, peak;
        bit                   descending, fired;
        logic [HOLDOFF_W-1:0] holdoff_left;
        result_t              pending_results[$];
        int                   mismatches, beats_seen;

        function new();
            regs = '{ALPHA_RST, MIN_PEAK_RST, MIN_DROP_RST, SLOPE_EPS_RST, HOLDOFF_RST};
            avg = '0;
            prev_avg = '0;
            peak = '0;
            descending = 1'b0;
            fired = 1'b0;
            holdoff_left = '0;
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ALPHA:     regs.smoothing_alpha = val;
                REG_MIN_PEAK:  regs.min_peak = val;
                REG_MIN_DROP:  regs.min_drop = val;
                REG_SLOPE_EPS: regs.slope_epsilon = val;
                REG_HOLDOFF:   regs.holdoff_length = val[HOLDOFF_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(item_t it);
            level_t      x;
            logic [63:0] mix;
            longint      slope, eps, sag;
            result_t     r;
            x = level_t'(it.sample) << FRACTION_BITS_DEF;
            r.strike = 1'b0;
            if (it.mode == MODE_LOAD) begin
                avg = x;
                prev_avg = x;
                peak = x;
                descending = 1'b0;
                holdoff_left = '0;
                fired = 1'b0;
            end
            else begin
                // epsilon is given in Q8.8
                eps = $signed(64'(regs.slope_epsilon) << (FRACTION_BITS_DEF - 8));
                mix = 64'(regs.smoothing_alpha) * 64'(x)
                    + (64'd65536 - 64'(regs.smoothing_alpha)) * 64'(avg) + 64'd32768;
                avg = level_t'(mix >> 16);
                slope = $signed(64'(avg)) - $signed(64'(prev_avg));
                prev_avg = avg;
                if (holdoff_left != 0)
                    holdoff_left = holdoff_left - 1'b1;
                else if (!descending) begin
                    if (avg > peak)
                        peak = avg;
                    if (64'(peak) >= (64'(regs.min_peak) << FRACTION_BITS_DEF) && slope < -eps)
                    begin
                        fired = 1'b0;
                        descending = 1'b1;
                    end
                end
                else begin
                    // signed: an average above the peak never strikes
                    sag = $signed(64'(peak)) - $signed(64'(avg));
                    if (!fired && sag >= $signed(64'(regs.min_drop) << FRACTION_BITS_DEF))
                    begin
                        fired = 1'b1;
                        holdoff_left = regs.holdoff_length;
                        r.strike = 1'b1;
                    end
                    else if (slope > eps) begin
                        peak = avg;
                        descending = 1'b0;
                    end
                end
            end
            r.smoothed = avg[FRACTION_BITS_DEF +: SAMPLE_W];
            r.in_descent = descending;
            pending_results.push_back(r);
        endfunction

        function void report(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t beat %0d %s: want s=%0b avg=%0d d=%0b got s=%0b avg=%0d d=%0b",
                         $realtime, beats_seen, what, want.strike, want.smoothed,
                         want.in_descent, got.strike, got.smoothed, got.in_descent);
        endfunction

        function void check_beat(result_t got);
            result_t want;
            beats_seen++;
            if (pending_results.size() == 0) begin
                report("with nothing pending", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.strike !== want.strike || got.smoothed !== want.smoothed
                || got.in_descent !== want.in_descent)
                report("mismatch", want, got);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 in_item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               out_result;
    logic                  cfg_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    strike_tracker tracker;
    bit            calm;
    bit            burst;
    int            holds_wanted;
    int            items_sent;

    strike_peak_drop_detector uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (in_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (out_result),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("** strike_peak_drop_detector: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_beat(out_result);
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_wanted) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0) begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic mode, input logic [SAMPLE_W-1:0] smp);
        item_t it;
        it.mode = mode;
        it.sample = smp;
        in_item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        tracker.note_sample(it);
        items_sent++;
        if (!calm && !burst && $urandom_range(0, 7) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_level(input int lvl, input int noise);
        int v;
        v = lvl + $urandom_range(0, 2 * noise) - noise;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        send_item(MODE_STEP, SAMPLE_W'(v));
    endtask

    // rise to a peak, fall back to zero, then settle at the baseline
    task automatic send_strike_shape();
        int base, top, rise, fall, tail, noise, k;
        base = $urandom_range(0, 3000);
        if ($urandom_range(0, 1) == 0)
            top = $urandom_range(base, 65535);
        else
            top = $urandom_range(base, base + 20000);
        rise = $urandom_range(1, 6);
        fall = $urandom_range(2, 12);
        tail = $urandom_range(0, 24);
        noise = $urandom_range(0, 400);
        if ($urandom_range(0, 5) == 0)
            send_item(MODE_LOAD, SAMPLE_W'(base));
        for (k = 1; k <= rise; k++)
            send_level(base + (top - base) * k / rise, noise);
        for (k = 1; k <= fall; k++)
            send_level(top - top * k / fall, noise);
        for (k = 0; k < tail; k++)
            send_level(base, noise);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic load_settings(input spd_cfg_t s);
        put_reg(REG_ALPHA, s.smoothing_alpha);
        put_reg(REG_MIN_PEAK, s.min_peak);
        put_reg(REG_MIN_DROP, s.min_drop);
        put_reg(REG_SLOPE_EPS, s.slope_epsilon);
        // junk in the unused upper bits
        put_reg(REG_HOLDOFF, {(CFG_DATA_W - HOLDOFF_W)'($urandom), s.holdoff_length});
        // indexes past the register list must be ignored
        put_reg(REG_HOLDOFF + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
        cfg_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        spd_cfg_t s;
        int       ph, start_count, pick;
        bit       paused;
        tracker = new();
        calm = 1'b0;
        burst = 1'b0;
        holds_wanted = 0;
        items_sent = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        in_item = '0;
        cfg_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: strike, holdoff, load in the middle of a holdoff
        send_item(MODE_LOAD, 16'h0000);
        repeat (4) send_item(MODE_STEP, 16'hFFFF);
        repeat (3) send_item(MODE_STEP, 16'h0000);
        send_item(MODE_LOAD, 16'hFFFF);
        send_item(MODE_STEP, 16'hFFFF);
        send_item(MODE_STEP, 16'h0000);
        send_item(MODE_STEP, 16'h0001);

        // zero holdoff: one strike per descent, then re-arm and strike again
        settle();
        load_settings('{ALPHA_RST, MIN_PEAK_RST, MIN_DROP_RST, 16'd0, 6'd0});
        send_item(MODE_LOAD, 16'h0000);
        repeat (3) send_item(MODE_STEP, 16'd40000);
        repeat (3) send_item(MODE_STEP, 16'h0000);
        send_item(MODE_STEP, 16'hFFFF);
        repeat (2) send_item(MODE_STEP, 16'h0000);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0: s = '{ALPHA_RST, MIN_PEAK_RST, MIN_DROP_RST, SLOPE_EPS_RST, HOLDOFF_RST};
                1: s = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 6'd0};
                2: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63};
                3: s = '{16'h0000, 16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom)};
                // wide dead band: the average can climb past the peak while descending
                4: s = '{16'($urandom_range(4000, 30000)), 16'($urandom_range(0, 8000)),
                         16'($urandom_range(0, 40000)), 16'($urandom_range(20000, 65535)),
                         6'($urandom_range(0, 63))};
                default: s = '{16'($urandom_range(2000, 65535)), 16'($urandom_range(0, 30000)),
                               16'($urandom_range(0, 15000)), 16'($urandom_range(0, 3000)),
                               6'($urandom_range(0, 63))};
            endcase
            load_settings(s);
            calm = (ph % 4 == 2) || (ph == NUM_PHASES - 1);
            paused = 1'b0;
            start_count = items_sent;
            if (ph == HOLD_PHASE) begin
                holds_wanted++;
                burst = 1'b1;
            end
            while (items_sent - start_count < PHASE_ITEMS)
            begin
                if (burst && items_sent - start_count >= 40)
                    burst = 1'b0;
                if (ph == DRAIN_PHASE && !paused && items_sent - start_count >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    drain();
                end
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    send_item(MODE_LOAD, SAMPLE_W'($urandom));
                else if (pick < 30)
                    send_item(MODE_STEP, SAMPLE_W'($urandom));
                else
                    send_strike_shape();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("** strike_peak_drop_detector: PASSED **");
        else
            $display("** strike_peak_drop_detector: FAILED **");
        $finish;
    end

endmodule
